// File: hw/rtl/ripple_wave_grid_step_unit_defines.svh
// Assertion macros shared by the ripple grid checker.
`ifndef RIPPLE_WAVE_GRID_STEP_UNIT_DEFINES_SVH
`define RIPPLE_WAVE_GRID_STEP_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RWG_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ripple grid: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define RWG_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ripple grid: next-cycle check failed");

`endif

// File: hw/rtl/rwg_pkg.sv
// Types, codes, constants and helper functions of the ripple grid step unit.
package rwg_pkg;

  localparam int GRID_W_DEF = 64;
  localparam int GRID_H_DEF = 64;

  localparam int FUNC_W     = 2;
  localparam int COORD_W    = 6;
  localparam int HEIGHT_W   = 16;
  localparam int DIM_W      = 7;
  localparam int DAMP_W     = 16;
  localparam int THR_W      = 15;
  localparam int APB_ADDR_W = 5;
  localparam int APB_DATA_W = 32;

  localparam logic [DIM_W-1:0]  COLS_RST    = 7'd64;
  localparam logic [DIM_W-1:0]  ROWS_RST    = 7'd64;
  localparam logic [DAMP_W-1:0] DAMP_RST    = 16'd57016;
  localparam logic [THR_W-1:0]  THR_RST     = 15'd20;
  localparam logic [THR_W-1:0]  TRIGGER_RST = 15'd3072;

  // Reciprocal of three, scaled by two to the RECIP3_SHIFT, rounded up.
  localparam logic [17:0] RECIP3       = 18'd174763;
  localparam int          RECIP3_SHIFT = 19;

  localparam logic [2:0] REG_COLS    = 3'd0;
  localparam logic [2:0] REG_ROWS    = 3'd1;
  localparam logic [2:0] REG_DAMP    = 3'd2;
  localparam logic [2:0] REG_THRESH  = 3'd3;
  localparam logic [2:0] REG_TRIGGER = 3'd4;

  typedef enum logic [1:0] {
    FUNC_LOAD  = 2'd0,
    FUNC_START = 2'd1,
    FUNC_TICK  = 2'd2,
    FUNC_READ  = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_SCAN,
    ST_DRAIN,
    ST_FETCH,
    ST_APPLY,
    ST_RESP
  } state_t;

  typedef enum logic [2:0] {
    PH_CENTER,
    PH_LEFT,
    PH_RIGHT,
    PH_UP,
    PH_DOWN
  } nb_phase_t;

  typedef struct packed {
    logic                       water;
    logic signed [HEIGHT_W-1:0] height_b;
    logic signed [HEIGHT_W-1:0] height_a;
  } cell_word_t;

  function automatic logic signed [HEIGHT_W-1:0] newest(cell_word_t w, logic sel);
    return sel ? w.height_b : w.height_a;
  endfunction

  function automatic logic signed [HEIGHT_W-1:0] older(cell_word_t w, logic sel);
    return sel ? w.height_a : w.height_b;
  endfunction

  function automatic cell_word_t set_newest(cell_word_t w, logic sel,
                                            logic signed [HEIGHT_W-1:0] h);
    cell_word_t r;
    r = w;
    if (sel) begin
      r.height_b = h;
    end else begin
      r.height_a = h;
    end
    return r;
  endfunction

endpackage

// File: hw/rtl/rwg_channel_if.sv
// Valid/ready channel interfaces for ripple grid items and results.
interface rwg_item_if;
  logic                                valid;
  logic                                ready;
  logic [rwg_pkg::FUNC_W-1:0]          func;
  logic [rwg_pkg::COORD_W-1:0]         col;
  logic [rwg_pkg::COORD_W-1:0]         row;
  logic                                is_water;
  logic signed [rwg_pkg::HEIGHT_W-1:0] start_height;

  modport source (output valid, func, col, row, is_water, start_height, input ready);
  modport sink (input valid, func, col, row, is_water, start_height, output ready);
endinterface

interface rwg_result_if;
  logic                                valid;
  logic                                ready;
  logic signed [rwg_pkg::HEIGHT_W-1:0] cell_height;
  logic                                cell_water;
  logic                                grid_active;
  logic                                tick_changed;

  modport source (output valid, cell_height, cell_water, grid_active, tick_changed,
                  input ready);
  modport sink (input valid, cell_height, cell_water, grid_active, tick_changed,
                output ready);
endinterface

// File: hw/rtl/ripple_wave_grid_step_unit.sv
// Top level of the ripple grid step unit: cell memory, tick sequencer and APB registers.
//
// Items arrive on in_ch and each produces exactly one result transaction on out_ch.
// A load item's result follows the write of its cell; a start or read item's result
// follows a read of its cell. A tick item on an active grid visits every
// interior cell of the grid in use, five memory reads per cell on the single read port,
// and gives its result once the datapath has drained; a tick on an idle grid skips the
// scan and is answered like a read.
// One item is in flight at a time; in_ch.ready is high only while no item is held.
// The result sits in an output register, so a new item is taken while the previous
// result still waits; if the receiver stalls, the next result waits inside the
// block and in_ch.ready stays low until the output register frees.
// Reset is synchronous. After reset a clearing pass writes zero to every cell,
// during which no item is taken; APB writes still work.
// Registers are written through APB at byte address 4 * index and should change
// only while no item is in flight.
module ripple_wave_grid_step_unit #(
  parameter int GRID_W = rwg_pkg::GRID_W_DEF,
  parameter int GRID_H = rwg_pkg::GRID_H_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  rwg_item_if.sink                          in_ch,
  rwg_result_if.source                      out_ch,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [rwg_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [rwg_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [rwg_pkg::APB_DATA_W-1:0]    prdata,
  output logic                              pready
);

  localparam int DEPTH = GRID_W * GRID_H;
  localparam int AW    = $clog2(DEPTH);
  localparam int HW    = rwg_pkg::HEIGHT_W;
  localparam int DW    = rwg_pkg::DIM_W;
  localparam logic [AW-1:0] ROW_STEP  = AW'(GRID_W);
  localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

  rwg_pkg::cell_word_t mem [DEPTH];
  rwg_pkg::cell_word_t rd_word;
  logic                mem_we;
  logic [AW-1:0]       mem_waddr;
  rwg_pkg::cell_word_t mem_wdata;
  logic [AW-1:0]       mem_raddr;

  rwg_pkg::state_t state, state_next;
  logic [AW-1:0]   clr_addr;

  logic [DW-1:0]                cols_in_use;
  logic [DW-1:0]                rows_in_use;
  logic [rwg_pkg::DAMP_W-1:0]   damping_factor;
  logic [rwg_pkg::THR_W-1:0]    thresh_level;
  logic [rwg_pkg::THR_W-1:0]    default_trigger;
  logic                         cfg_write;
  logic [2:0]                   reg_idx;

  logic bank_sel;
  logic active;
  logic tick_chg;

  rwg_pkg::func_t            it_func;
  logic [rwg_pkg::COORD_W-1:0] it_col;
  logic [rwg_pkg::COORD_W-1:0] it_row;
  logic                      it_wet;
  logic signed [HW-1:0]      it_start;
  logic                      in_fire;

  logic [DW-1:0]        cols_eff;
  logic [DW-1:0]        rows_eff;
  logic                 in_grid;
  logic [31:0]          it_addr_full;
  logic [AW-1:0]        it_addr;
  logic signed [HW-1:0] h_sel;
  logic signed [HW-1:0] start_val;
  logic                 start_wr;

  logic [DW-1:0]         scan_r;
  logic [DW-1:0]         scan_c;
  logic [AW-1:0]         row_base;
  rwg_pkg::nb_phase_t    phase;
  logic [AW-1:0]         scan_center;
  logic [AW-1:0]         scan_addr;
  logic                  scan_last;

  logic                  tk_rd_valid;
  rwg_pkg::nb_phase_t    tk_rd_phase;
  logic [AW-1:0]         tk_rd_addr;

  rwg_pkg::cell_word_t   ctr_word;
  logic [AW-1:0]         ctr_addr;
  logic signed [17:0]    acc_sum;
  logic [2:0]            acc_n;
  logic signed [HW-1:0]  nb_add;
  logic signed [17:0]    sum_plus;
  logic [2:0]            n_plus;

  logic                  s1_valid;
  logic signed [17:0]    s1_sum;
  logic [2:0]            s1_n;
  rwg_pkg::cell_word_t   s1_word;
  logic [AW-1:0]         s1_addr;

  logic signed [18:0]    sum2;
  logic                  neg2;
  logic [18:0]           mag2;
  logic [36:0]           p3;
  logic [16:0]           q2;
  logic signed [17:0]    spread2;

  logic                  s2_valid;
  logic signed [17:0]    s2_spread;
  rwg_pkg::cell_word_t   s2_word;
  logic [AW-1:0]         s2_addr;

  logic signed [18:0]    diff3;
  logic signed [16:0]    damp_s;
  logic signed [35:0]    prod3;

  logic                  s3_valid;
  logic signed [35:0]    s3_prod;
  rwg_pkg::cell_word_t   s3_word;
  logic [AW-1:0]         s3_addr;

  logic [35:0]           mag4;
  logic [35:0]           rnd4;
  logic [19:0]           r4;
  logic signed [HW-1:0]  v4;
  logic [HW-1:0]         vmag4;
  rwg_pkg::cell_word_t   tick_word;
  logic                  pipe_empty;

  logic signed [HW-1:0]  out_height;
  logic                  out_water;
  logic                  out_active;
  logic                  out_changed;
  logic                  out_valid;
  logic signed [HW-1:0]  resp_height;
  logic                  resp_water;
  logic                  resp_active;
  logic                  resp_changed;
  logic                  out_free;

  assign in_ch.ready         = (state == rwg_pkg::ST_IDLE);
  assign in_fire             = in_ch.valid && in_ch.ready;
  assign out_ch.valid        = out_valid;
  assign out_ch.cell_height  = out_height;
  assign out_ch.cell_water   = out_water;
  assign out_ch.grid_active  = out_active;
  assign out_ch.tick_changed = out_changed;
  assign out_free            = !out_valid || out_ch.ready;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign reg_idx   = paddr[4:2];

  always_comb begin
    case (reg_idx)
      rwg_pkg::REG_COLS:    prdata = 32'(cols_in_use);
      rwg_pkg::REG_ROWS:    prdata = 32'(rows_in_use);
      rwg_pkg::REG_DAMP:    prdata = 32'(damping_factor);
      rwg_pkg::REG_THRESH:  prdata = 32'(thresh_level);
      rwg_pkg::REG_TRIGGER: prdata = 32'(default_trigger);
      default:              prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cols_in_use      <= rwg_pkg::COLS_RST;
      rows_in_use      <= rwg_pkg::ROWS_RST;
      damping_factor   <= rwg_pkg::DAMP_RST;
      thresh_level     <= rwg_pkg::THR_RST;
      default_trigger  <= rwg_pkg::TRIGGER_RST;
    end else if (cfg_write) begin
      case (reg_idx)
        rwg_pkg::REG_COLS:    cols_in_use      <= pwdata[DW-1:0];
        rwg_pkg::REG_ROWS:    rows_in_use      <= pwdata[DW-1:0];
        rwg_pkg::REG_DAMP:    damping_factor   <= pwdata[rwg_pkg::DAMP_W-1:0];
        rwg_pkg::REG_THRESH:  thresh_level     <= pwdata[rwg_pkg::THR_W-1:0];
        rwg_pkg::REG_TRIGGER: default_trigger  <= pwdata[rwg_pkg::THR_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Effective grid size and addressing of the held item.
  always_comb begin
    if (cols_in_use < 7'd3) begin
      cols_eff = 7'd3;
    end else if (32'(cols_in_use) > 32'(GRID_W)) begin
      cols_eff = DW'(GRID_W);
    end else begin
      cols_eff = cols_in_use;
    end
    if (rows_in_use < 7'd3) begin
      rows_eff = 7'd3;
    end else if (32'(rows_in_use) > 32'(GRID_H)) begin
      rows_eff = DW'(GRID_H);
    end else begin
      rows_eff = rows_in_use;
    end
  end

  assign in_grid      = (DW'(it_col) < cols_eff) && (DW'(it_row) < rows_eff);
  assign it_addr_full = 32'(it_row) * 32'(GRID_W) + 32'(it_col);
  assign it_addr      = in_grid ? it_addr_full[AW-1:0] : '0;

  assign h_sel     = (it_start == '0) ? $signed({1'b0, default_trigger}) : it_start;
  assign start_val = (h_sel == -16'sd32768) ? 16'sd32767 : -h_sel;
  assign start_wr  = (it_func == rwg_pkg::FUNC_START) && in_grid && rd_word.water;

  // Neighbor read address of the current scan step.
  assign scan_center = row_base + AW'(scan_c);
  always_comb begin
    case (phase)
      rwg_pkg::PH_CENTER: scan_addr = scan_center;
      rwg_pkg::PH_LEFT:   scan_addr = scan_center - AW'(1);
      rwg_pkg::PH_RIGHT:  scan_addr = scan_center + AW'(1);
      rwg_pkg::PH_UP:     scan_addr = scan_center - ROW_STEP;
      rwg_pkg::PH_DOWN:   scan_addr = scan_center + ROW_STEP;
      default:            scan_addr = scan_center;
    endcase
  end
  assign scan_last = (phase == rwg_pkg::PH_DOWN) && (scan_c == cols_eff - 7'd2) &&
                     (scan_r == rows_eff - 7'd2);

  // Neighbor accumulation.
  assign nb_add   = rd_word.water ? rwg_pkg::older(rd_word, bank_sel) : '0;
  assign sum_plus = acc_sum + 18'(nb_add);
  assign n_plus   = acc_n + 3'(rd_word.water);

  // Spread: twice the neighbor mean, truncated toward zero.
  always_comb begin
    sum2 = {s1_sum, 1'b0};
    neg2 = sum2[18];
    mag2 = neg2 ? -sum2 : sum2;
    p3   = 37'(mag2) * 37'(rwg_pkg::RECIP3);
    case (s1_n)
      3'd1:    q2 = mag2[16:0];
      3'd2:    q2 = mag2[17:1];
      3'd3:    q2 = p3[rwg_pkg::RECIP3_SHIFT+16:rwg_pkg::RECIP3_SHIFT];
      3'd4:    q2 = mag2[18:2];
      default: q2 = '0;
    endcase
    spread2 = neg2 ? -$signed({1'b0, q2}) : $signed({1'b0, q2});
  end

  assign diff3  = 19'(s2_spread) - 19'(rwg_pkg::newest(s2_word, bank_sel));
  assign damp_s = $signed({1'b0, damping_factor});
  assign prod3  = 36'(diff3) * 36'(damp_s);

  // Rounding to nearest, ties away from zero, then saturation.
  always_comb begin
    mag4 = s3_prod[35] ? -s3_prod : s3_prod;
    rnd4 = mag4 + 36'd32768;
    r4   = rnd4[35:16];
    if (!s3_prod[35]) begin
      if (r4 > 20'd32767) begin
        v4    = 16'sd32767;
        vmag4 = 16'd32767;
      end else begin
        v4    = $signed(r4[HW-1:0]);
        vmag4 = r4[HW-1:0];
      end
    end else begin
      if (r4 >= 20'd32768) begin
        v4    = -16'sd32768;
        vmag4 = 16'd32768;
      end else begin
        v4    = -$signed(r4[HW-1:0]);
        vmag4 = r4[HW-1:0];
      end
    end
    tick_word = rwg_pkg::set_newest(s3_word, bank_sel, v4);
  end

  assign pipe_empty = !tk_rd_valid && !s1_valid && !s2_valid && !s3_valid;

  always_comb begin
    state_next = state;
    mem_we     = 1'b0;
    mem_waddr  = clr_addr;
    mem_wdata  = '0;
    mem_raddr  = scan_addr;
    case (state)
      rwg_pkg::ST_CLEAR: begin
        mem_we = 1'b1;
        if (clr_addr == LAST_ADDR) begin
          state_next = rwg_pkg::ST_IDLE;
        end
      end
      rwg_pkg::ST_IDLE: begin
        if (in_fire) begin
          state_next = rwg_pkg::ST_EXEC;
        end
      end
      rwg_pkg::ST_EXEC: begin
        case (it_func)
          rwg_pkg::FUNC_LOAD: begin
            if (in_grid) begin
              mem_we    = 1'b1;
              mem_waddr = it_addr;
              mem_wdata = '{water: it_wet, height_b: '0, height_a: '0};
            end
            state_next = rwg_pkg::ST_RESP;
          end
          rwg_pkg::FUNC_TICK:  state_next = active ? rwg_pkg::ST_SCAN : rwg_pkg::ST_FETCH;
          rwg_pkg::FUNC_START: state_next = rwg_pkg::ST_FETCH;
          rwg_pkg::FUNC_READ:  state_next = rwg_pkg::ST_FETCH;
          default:             state_next = rwg_pkg::ST_FETCH;
        endcase
      end
      rwg_pkg::ST_SCAN: begin
        if (scan_last) begin
          state_next = rwg_pkg::ST_DRAIN;
        end
      end
      rwg_pkg::ST_DRAIN: begin
        if (pipe_empty) begin
          state_next = rwg_pkg::ST_FETCH;
        end
      end
      rwg_pkg::ST_FETCH: begin
        mem_raddr  = it_addr;
        state_next = rwg_pkg::ST_APPLY;
      end
      rwg_pkg::ST_APPLY: begin
        if (start_wr) begin
          mem_we    = 1'b1;
          mem_waddr = it_addr;
          mem_wdata = rwg_pkg::set_newest(rd_word, bank_sel, start_val);
        end
        state_next = rwg_pkg::ST_RESP;
      end
      rwg_pkg::ST_RESP: begin
        if (out_free) begin
          state_next = rwg_pkg::ST_IDLE;
        end
      end
      default: state_next = rwg_pkg::ST_IDLE;
    endcase
    if (s3_valid) begin
      mem_we    = 1'b1;
      mem_waddr = s3_addr;
      mem_wdata = tick_word;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_word <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rwg_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr    <= '0;
      bank_sel    <= 1'b0;
      active      <= 1'b0;
      tick_chg    <= 1'b0;
      tk_rd_valid <= 1'b0;
      s1_valid    <= 1'b0;
      s2_valid    <= 1'b0;
      s3_valid    <= 1'b0;
      out_valid   <= 1'b0;
      phase       <= rwg_pkg::PH_CENTER;
    end else begin
      if (state == rwg_pkg::ST_CLEAR) begin
        clr_addr <= clr_addr + AW'(1);
      end
      tk_rd_valid <= (state == rwg_pkg::ST_SCAN);
      s1_valid    <= tk_rd_valid && (tk_rd_phase == rwg_pkg::PH_DOWN) && ctr_word.water;
      s2_valid    <= s1_valid;
      s3_valid    <= s2_valid;
      if (state == rwg_pkg::ST_EXEC) begin
        tick_chg <= 1'b0;
        phase    <= rwg_pkg::PH_CENTER;
        if (it_func == rwg_pkg::FUNC_TICK && active) begin
          bank_sel <= ~bank_sel;
        end
      end
      if (s3_valid && (vmag4 > {1'b0, thresh_level})) begin
        tick_chg <= 1'b1;
      end
      if (state == rwg_pkg::ST_SCAN) begin
        case (phase)
          rwg_pkg::PH_CENTER: phase <= rwg_pkg::PH_LEFT;
          rwg_pkg::PH_LEFT:   phase <= rwg_pkg::PH_RIGHT;
          rwg_pkg::PH_RIGHT:  phase <= rwg_pkg::PH_UP;
          rwg_pkg::PH_UP:     phase <= rwg_pkg::PH_DOWN;
          default:            phase <= rwg_pkg::PH_CENTER;
        endcase
      end
      if (state == rwg_pkg::ST_DRAIN && pipe_empty) begin
        active <= tick_chg;
      end
      if (state == rwg_pkg::ST_APPLY && start_wr) begin
        active <= 1'b1;
      end
      if (state == rwg_pkg::ST_RESP && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload and datapath registers.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      it_func  <= rwg_pkg::func_t'(in_ch.func);
      it_col   <= in_ch.col;
      it_row   <= in_ch.row;
      it_wet   <= in_ch.is_water;
      it_start <= in_ch.start_height;
    end
    if (state == rwg_pkg::ST_EXEC) begin
      scan_r   <= DW'(1);
      scan_c   <= DW'(1);
      row_base <= ROW_STEP;
      if (it_func == rwg_pkg::FUNC_LOAD) begin
        resp_height  <= '0;
        resp_water   <= in_grid && it_wet;
        resp_active  <= active;
        resp_changed <= 1'b0;
      end
    end
    if (state == rwg_pkg::ST_SCAN && phase == rwg_pkg::PH_DOWN) begin
      if (scan_c == cols_eff - 7'd2) begin
        scan_c   <= DW'(1);
        scan_r   <= scan_r + DW'(1);
        row_base <= row_base + ROW_STEP;
      end else begin
        scan_c <= scan_c + DW'(1);
      end
    end
    tk_rd_phase <= phase;
    tk_rd_addr  <= scan_center;
    if (tk_rd_valid) begin
      case (tk_rd_phase)
        rwg_pkg::PH_CENTER: begin
          ctr_word <= rd_word;
          ctr_addr <= tk_rd_addr;
          acc_sum  <= '0;
          acc_n    <= '0;
        end
        rwg_pkg::PH_DOWN: begin
          s1_sum  <= sum_plus;
          s1_n    <= n_plus;
          s1_word <= ctr_word;
          s1_addr <= ctr_addr;
        end
        default: begin
          acc_sum <= sum_plus;
          acc_n   <= n_plus;
        end
      endcase
    end
    s2_spread <= spread2;
    s2_word   <= s1_word;
    s2_addr   <= s1_addr;
    s3_prod   <= prod3;
    s3_word   <= s2_word;
    s3_addr   <= s2_addr;
    if (state == rwg_pkg::ST_APPLY) begin
      if (!in_grid) begin
        resp_height <= '0;
      end else if (start_wr) begin
        resp_height <= start_val;
      end else begin
        resp_height <= rwg_pkg::newest(rd_word, bank_sel);
      end
      resp_water   <= in_grid && rd_word.water;
      resp_active  <= active || start_wr;
      resp_changed <= (it_func == rwg_pkg::FUNC_TICK) && tick_chg;
    end
    if (state == rwg_pkg::ST_RESP && out_free) begin
      out_height  <= resp_height;
      out_water   <= resp_water;
      out_active  <= resp_active;
      out_changed <= resp_changed;
    end
  end

endmodule

// File: hw/rtl/rwg_checker.sv
// Port-level assertions for the ripple grid step unit and their bind statement.
`include "ripple_wave_grid_step_unit_defines.svh"

module rwg_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                in_ready,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic signed [rwg_pkg::HEIGHT_W-1:0] cell_height,
  input logic                                cell_water,
  input logic                                grid_active,
  input logic                                tick_changed
);

  `RWG_ASSERT_NEXT(a_out_valid_held, clk, rst, out_valid && !out_ready, out_valid)

  `RWG_ASSERT_NEXT(a_out_payload_held, clk, rst, out_valid && !out_ready, $stable(cell_height) && $stable(cell_water) && $stable(grid_active) && $stable(tick_changed))

  `RWG_ASSERT_SAME(a_changed_keeps_active, clk, rst, out_valid && tick_changed, grid_active)

  `RWG_ASSERT_SAME(a_dry_cell_flat, clk, rst, out_valid && !cell_water, cell_height == '0)

  `RWG_ASSERT_SAME(a_clear_blocks_items, clk, rst, $past(rst), !in_ready)

endmodule

bind ripple_wave_grid_step_unit rwg_checker u_rwg_checker (
  .clk          (clk),
  .rst          (rst),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .cell_height  (out_ch.cell_height),
  .cell_water   (out_ch.cell_water),
  .grid_active  (out_ch.grid_active),
  .tick_changed (out_ch.tick_changed)
);
